FILE: design/awm_pkg.sv
// Package for the alias keyword whole-word matcher.
// Holds the alias ROM, its lengths and the character class helpers.
// No dependencies.
package awm_pkg;

    localparam int MAX_TEXT_DEF          = 1023;
    localparam int MAX_ALIAS_LEN_DEF     = 32;
    localparam int GROUP_COUNT_DEF       = 6;
    localparam int ALIASES_PER_GROUP_DEF = 12;

    localparam int ROM_GROUPS = 6;
    localparam int ROM_SLOTS  = 12;
    localparam int ROM_BYTES  = 32;
    localparam int ROM_BITS   = 8 * ROM_BYTES;

    localparam logic [2:0] SEL_ALL = 3'd6;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_HYPHEN = 8'h2d;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5f;

    localparam int GROUP_W = 3;
    localparam int ALIAS_W = 4;
    localparam int OUT_DATA_W = 8;

    typedef logic [ROM_BITS-1:0] alias_vec_t;

    // Alias text, last character in the lowest byte.
    function automatic alias_vec_t alias_bytes(input int g, input int a);
        alias_vec_t v;
        v = '0;
        if (g < ROM_GROUPS && a < ROM_SLOTS) begin
            case (g * ROM_SLOTS + a)
                0:  v = "grapefruit";
                1:  v = "toranja";
                2:  v = "pomelo";
                3:  v = "pomelo-grapefruit";
                4:  v = "citrus paradisi";
                12: v = "crian\303\247a";
                13: v = "crianca";
                14: v = "beb\303\252";
                15: v = "bebe";
                16: v = "infantil";
                17: v = "menor";
                18: v = "nenem";
                24: v = "alergia";
                25: v = "alergico";
                26: v = "al\303\251rgico";
                27: v = "hipersensibilidade";
                28: v = "intolerancia";
                36: v = "saneante";
                37: v = "desinfetante";
                38: v = "agua sanitaria";
                39: v = "\303\241gua sanit\303\241ria";
                40: v = "cloro";
                41: v = "bleach";
                48: v = "recipiente fechado";
                49: v = "frasco fechado";
                50: v = "pote fechado";
                51: v = "container fechado";
                60: v = "energia";
                61: v = "aquecimento";
                62: v = "chama";
                63: v = "fogo";
                64: v = "microondas";
                65: v = "micro-ondas";
                default: v = '0;
            endcase
        end
        return v;
    endfunction

    function automatic int alias_len(input int g, input int a);
        int n;
        n = 0;
        if (g < ROM_GROUPS && a < ROM_SLOTS) begin
            case (g * ROM_SLOTS + a)
                0:  n = 10;
                1:  n = 7;
                2:  n = 6;
                3:  n = 17;
                4:  n = 15;
                12: n = 8;
                13: n = 7;
                14: n = 5;
                15: n = 4;
                16: n = 8;
                17: n = 5;
                18: n = 5;
                24: n = 7;
                25: n = 8;
                26: n = 9;
                27: n = 18;
                28: n = 12;
                36: n = 8;
                37: n = 12;
                38: n = 14;
                39: n = 16;
                40: n = 5;
                41: n = 6;
                48: n = 18;
                49: n = 14;
                50: n = 12;
                51: n = 17;
                60: n = 7;
                61: n = 11;
                62: n = 5;
                63: n = 4;
                64: n = 10;
                65: n = 11;
                default: n = 0;
            endcase
        end
        return n;
    endfunction

    function automatic logic is_boundary(input logic [7:0] c);
        return (c == CH_SPACE) || c[7];
    endfunction

    function automatic logic is_word(input logic [7:0] b);
        return (b >= 8'h61 && b <= 8'h7a) || (b >= 8'h41 && b <= 8'h5a) ||
               (b >= 8'h30 && b <= 8'h39) || (b == CH_HYPHEN) ||
               (b == CH_UNDERSCORE) || b[7];
    endfunction

endpackage

FILE: design/awm_char_cell.sv
// One stage of the character window shift line.
// Depends on awm_pkg.
module awm_char_cell (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       shift_en,
    input  logic       clear,
    input  logic [7:0] char_in,
    output logic [7:0] char_next,
    output logic [7:0] char_q
);
    logic [7:0] char_reg;

    // value after this beat, used by the alias cells
    assign char_next = shift_en ? char_in : char_reg;
    assign char_q    = char_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            char_reg <= awm_pkg::CH_SPACE;
        end else begin
            char_reg <= char_next;
        end
    end
endmodule

FILE: design/awm_alias_cell.sv
// One alias slot: compares the window against its ROM pattern and
// keeps the pending end match and found bits. Depends on awm_pkg.
module awm_alias_cell #(
    parameter int G             = 0,
    parameter int A             = 0,
    parameter int MAX_ALIAS_LEN = awm_pkg::MAX_ALIAS_LEN_DEF,
    parameter int CNT_W         = 10
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          take,
    input  logic                          clear,
    input  logic                          resolve,
    input  logic [MAX_ALIAS_LEN-1:0][7:0] win_next,
    input  logic [CNT_W-1:0]              count_next,
    output logic                          hit_next
);
    localparam int LEN = awm_pkg::alias_len(G, A);
    localparam int USE = (LEN > 0) && (LEN <= MAX_ALIAS_LEN);
    localparam int KN  = (LEN < MAX_ALIAS_LEN) ? LEN : MAX_ALIAS_LEN;
    localparam awm_pkg::alias_vec_t PAT = awm_pkg::alias_bytes(G, A);

    logic pending_reg, pending_next;
    logic found_reg, found_next;
    logic chars_eq, left_ok, match;

    always_comb begin
        chars_eq = 1'b1;
        for (int k = 0; k < KN; k++) begin
            if (win_next[k] != PAT[8*k +: 8]) chars_eq = 1'b0;
        end
    end

    generate
        if (USE == 0) begin : g_unused
            assign left_ok = 1'b0;
        end else if (LEN < MAX_ALIAS_LEN) begin : g_bound
            assign left_ok = awm_pkg::is_boundary(win_next[LEN]) &&
                             (count_next >= CNT_W'(LEN));
        end else begin : g_full
            assign left_ok = (count_next == CNT_W'(LEN));
        end
    endgenerate

    assign match        = chars_eq && left_ok;
    assign found_next   = found_reg || (take && resolve && pending_reg);
    assign pending_next = take ? match : pending_reg;
    assign hit_next     = found_next || pending_next;

    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            pending_reg <= 1'b0;
            found_reg   <= 1'b0;
        end else begin
            pending_reg <= pending_next;
            found_reg   <= found_next;
        end
    end
endmodule

FILE: design/alias_keyword_whole_word_matcher.sv
// Alias keyword whole-word matcher: top level.
// Result beat is registered: it appears in the cycle after the last text beat is accepted.
// Throughput: one text byte per cycle, texts back to back; the output register
// frees s_tready whenever the result slot is empty or drained in that cycle.
// Reset (aresetn low, synchronous): window to spaces, match bits cleared,
// selector to all groups, output empty. Depends on awm_pkg and both cells.
module alias_keyword_whole_word_matcher #(
    parameter int MAX_TEXT          = awm_pkg::MAX_TEXT_DEF,
    parameter int MAX_ALIAS_LEN     = awm_pkg::MAX_ALIAS_LEN_DEF,
    parameter int GROUP_COUNT       = awm_pkg::GROUP_COUNT_DEF,
    parameter int ALIASES_PER_GROUP = awm_pkg::ALIASES_PER_GROUP_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] text_byte
    input  logic       s_tlast,   // end_of_text
    input  logic [2:0] s_tuser,   // [2:0] group_select
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [awm_pkg::OUT_DATA_W-1:0] m_tdata  // [0] found, [3:1] group_index,
                                                     // [7:4] alias_index
);
    localparam int CNT_W = $clog2(MAX_TEXT + 1);
    localparam int NA    = GROUP_COUNT * ALIASES_PER_GROUP;

    logic                          accept, done;
    logic [7:0]                    lc_char;
    logic                          have, take;
    logic                          last_sp_reg, last_sp_next;
    logic [CNT_W-1:0]              count_reg, count_next;
    logic [2:0]                    sel_reg, sel_now;
    logic                          start_reg;
    logic [MAX_ALIAS_LEN-1:0][7:0] win_next, win_q;
    logic [NA-1:0]                 hit_next;

    logic                          m_valid_reg;
    logic [awm_pkg::OUT_DATA_W-1:0] m_data_reg, res_data;

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign done     = accept && s_tlast;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // normalisation: lowercase letters, separator runs fold into one space
    always_comb begin
        lc_char = s_tdata;
        have    = 1'b1;
        if (awm_pkg::is_word(s_tdata)) begin
            if (s_tdata >= 8'h41 && s_tdata <= 8'h5a) lc_char = s_tdata | 8'h20;
        end else begin
            lc_char = awm_pkg::CH_SPACE;
            have    = !last_sp_reg;
        end
    end

    assign take         = accept && have && (count_reg < CNT_W'(MAX_TEXT));
    assign count_next   = take ? count_reg + 1'b1 : count_reg;
    assign last_sp_next = take ? (lc_char == awm_pkg::CH_SPACE) : last_sp_reg;
    assign sel_now      = start_reg ? s_tuser : sel_reg;

    // window shift line, newest character in stage 0
    genvar i, g, a;
    generate
        for (i = 0; i < MAX_ALIAS_LEN; i++) begin : g_win
            awm_char_cell u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .shift_en  (take),
                .clear     (done),
                .char_in   ((i == 0) ? lc_char : win_q[(i == 0) ? 0 : i-1]),
                .char_next (win_next[i]),
                .char_q    (win_q[i])
            );
        end
        for (g = 0; g < GROUP_COUNT; g++) begin : g_grp
            for (a = 0; a < ALIASES_PER_GROUP; a++) begin : g_ali
                awm_alias_cell #(
                    .G             (g),
                    .A             (a),
                    .MAX_ALIAS_LEN (MAX_ALIAS_LEN),
                    .CNT_W         (CNT_W)
                ) u_alias (
                    .aclk       (aclk),
                    .aresetn    (aresetn),
                    .take       (take),
                    .clear      (done),
                    .resolve    (awm_pkg::is_boundary(lc_char)),
                    .win_next   (win_next),
                    .count_next (count_next),
                    .hit_next   (hit_next[g*ALIASES_PER_GROUP + a])
                );
            end
        end
    endgenerate

    // winner: first permitted hit in table order
    always_comb begin
        logic got;
        got      = 1'b0;
        res_data = '0;
        for (int gi = 0; gi < GROUP_COUNT; gi++) begin
            for (int ai = 0; ai < ALIASES_PER_GROUP; ai++) begin
                if (!got && hit_next[gi*ALIASES_PER_GROUP + ai] &&
                    (sel_now == awm_pkg::SEL_ALL || 32'(sel_now) == gi)) begin
                    got      = 1'b1;
                    res_data = {ai[awm_pkg::ALIAS_W-1:0], gi[awm_pkg::GROUP_W-1:0], 1'b1};
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            last_sp_reg <= 1'b1;
            count_reg   <= '0;
            sel_reg     <= awm_pkg::SEL_ALL;
            start_reg   <= 1'b1;
        end else begin
            if (done) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (accept) begin
                sel_reg <= sel_now;
            end
            if (done) begin
                last_sp_reg <= 1'b1;
                count_reg   <= '0;
                start_reg   <= 1'b1;
            end else begin
                last_sp_reg <= last_sp_next;
                count_reg   <= count_next;
                if (accept) start_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (done) begin
            m_data_reg <= res_data;
        end
    end
endmodule

FILE: tb/tb_alias_keyword_whole_word_matcher.sv
// Testbench for the alias keyword whole-word matcher.
// Drives texts as byte beats, predicts each result with its own matcher model
// and compares beat by beat; depends on awm_pkg and the block only.
module tb_alias_keyword_whole_word_matcher;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TEXT_CAP  = 1023;
    localparam int WIN_LEN   = 32;
    localparam int N_GROUPS  = 6;
    localparam int N_SLOTS   = 12;

    typedef struct packed {
        logic [3:0] alias_idx;
        logic [2:0] group_idx;
        logic       found;
    } verdict_t;

    typedef struct {
        logic [7:0] b;
        logic       last;
        logic [2:0] sel;
        logic       has_fixed;
        verdict_t   fixed;
    } text_row_t;

    logic       aclk;
    logic       aresetn;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic       s_tlast;
    logic [2:0] s_tuser;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;

    alias_keyword_whole_word_matcher uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tlast(s_tlast), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // Alias ROM, first character first; empty slots are the empty string
    string phrase_rom [N_GROUPS][N_SLOTS];

    // Predictor state
    logic [7:0] win [WIN_LEN];
    logic       sep_pending;
    int         norm_count;
    logic       end_hit [N_GROUPS][N_SLOTS];
    logic       seen    [N_GROUPS][N_SLOTS];
    logic [2:0] text_sel;
    logic       text_start;

    verdict_t   verdicts_due [$];
    int         errors;
    int         results_seen;
    int         beats_sent;
    logic       long_hold;

    initial begin
        phrase_rom[0] = '{"grapefruit", "toranja", "pomelo", "pomelo-grapefruit",
                          "citrus paradisi", "", "", "", "", "", "", ""};
        phrase_rom[1] = '{"crian\303\247a", "crianca", "beb\303\252", "bebe",
                          "infantil", "menor", "nenem", "", "", "", "", ""};
        phrase_rom[2] = '{"alergia", "alergico", "al\303\251rgico",
                          "hipersensibilidade", "intolerancia", "", "", "", "", "", "", ""};
        phrase_rom[3] = '{"saneante", "desinfetante", "agua sanitaria",
                          "\303\241gua sanit\303\241ria", "cloro", "bleach",
                          "", "", "", "", "", ""};
        phrase_rom[4] = '{"recipiente fechado", "frasco fechado", "pote fechado",
                          "container fechado", "", "", "", "", "", "", "", ""};
        phrase_rom[5] = '{"energia", "aquecimento", "chama", "fogo", "microondas",
                          "micro-ondas", "", "", "", "", "", ""};
    end

    function automatic logic word_byte(logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") ||
               (b >= "0" && b <= "9") || b == awm_pkg::CH_HYPHEN ||
               b == awm_pkg::CH_UNDERSCORE || b[7];
    endfunction

    function automatic logic bound_char(logic [7:0] c);
        return c == awm_pkg::CH_SPACE || c[7];
    endfunction

    task automatic clear_text_state();
        foreach (win[i]) win[i] = awm_pkg::CH_SPACE;
        sep_pending = 1'b1;
        norm_count = 0;
        foreach (end_hit[g, a]) begin
            end_hit[g][a] = 1'b0;
            seen[g][a]    = 1'b0;
        end
        text_start = 1'b1;
    endtask

    task automatic shift_char(logic [7:0] c);
        logic hit;
        int   len;
        foreach (end_hit[g, a]) begin
            if (bound_char(c) && end_hit[g][a]) seen[g][a] = 1'b1;
            end_hit[g][a] = 1'b0;
        end
        for (int i = WIN_LEN - 1; i > 0; i--) win[i] = win[i-1];
        win[0] = c;
        sep_pending = (c == awm_pkg::CH_SPACE);
        norm_count++;
        foreach (end_hit[g, a]) begin
            len = phrase_rom[g][a].len();
            if (len == 0 || norm_count < len) continue;
            hit = 1'b1;
            for (int k = 0; k < len; k++)
                if (win[k] != phrase_rom[g][a][len-1-k]) hit = 1'b0;
            if (!hit) continue;
            // longest alias is shorter than the window, so a left neighbour exists
            end_hit[g][a] = bound_char(win[len]);
        end
    endtask

    // Advances the predictor by one beat; queues the verdict on the last beat
    task automatic predict_beat(logic [7:0] b, logic last, logic [2:0] sel);
        verdict_t v;
        logic     have;
        logic [7:0] c;
        if (text_start) begin
            text_sel   = sel;
            text_start = 1'b0;
        end
        have = 1'b0;
        c = awm_pkg::CH_SPACE;
        if (word_byte(b)) begin
            c = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
            have = 1'b1;
        end else if (!sep_pending) begin
            have = 1'b1;
        end
        if (have && norm_count < TEXT_CAP) shift_char(c);
        if (!last) return;
        v = '0;
        for (int g = 0; g < N_GROUPS && !v.found; g++) begin
            if (!(text_sel == awm_pkg::SEL_ALL || text_sel == g)) continue;
            for (int a = 0; a < N_SLOTS; a++)
                if (seen[g][a] || end_hit[g][a]) begin
                    v.found = 1'b1;
                    v.group_idx = 3'(g);
                    v.alias_idx = 4'(a);
                    break;
                end
        end
        verdicts_due.push_back(v);
        clear_text_state();
    endtask

    // Clock
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Limit on the whole run
    initial begin
        #60ms;
        $display("tb: failure");
        $finish;
    end

    // Receiver: own stall pattern, plus one long hold-off on request
    initial begin
        int hold;
        m_tready = 1'b0;
        hold = 0;
        forever begin
            @(posedge aclk);
            if (long_hold && hold == 0) hold = 300;
            if (hold > 0) begin
                hold--;
                m_tready <= 1'b0;
            end else if (results_seen % 64 < 20) begin
                m_tready <= 1'b1;   // stretch with no stalls
            end else begin
                m_tready <= ($urandom_range(0, 3) != 0);
            end
        end
    end

    // Checker: compares each result beat with the oldest verdict due
    initial begin
        verdict_t got, want;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                got = m_tdata;
                results_seen++;
                if (verdicts_due.size() == 0) begin
                    $display("%0t: unexpected result beat %h", $time, m_tdata);
                    errors++;
                end else begin
                    want = verdicts_due.pop_front();
                    if (got.found !== want.found) begin
                        $display("%0t: found exp %0d got %0d", $time, want.found, got.found);
                        errors++;
                    end
                    if (got.group_idx !== want.group_idx) begin
                        $display("%0t: group exp %0d got %0d", $time,
                                 want.group_idx, got.group_idx);
                        errors++;
                    end
                    if (got.alias_idx !== want.alias_idx) begin
                        $display("%0t: alias exp %0d got %0d", $time,
                                 want.alias_idx, got.alias_idx);
                        errors++;
                    end
                end
            end
        end
    end

    text_row_t rows [$];
    int        burst;

    // Sends one beat, with burst/gap idling; checks any typed-in verdict
    task automatic send_beat(logic [7:0] b, logic last, logic [2:0] sel,
                             logic has_fixed = 1'b0, verdict_t fixed = '0);
        if (burst == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            burst = $urandom_range(1, 40);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        s_tuser  <= sel;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        burst--;
        beats_sent++;
        predict_beat(b, last, sel);
        if (last && has_fixed && verdicts_due[$] !== fixed) begin
            $display("%0t: table row exp %h predictor %h", $time, fixed, verdicts_due[$]);
            errors++;
        end
    endtask

    task automatic add_text(string s, logic [2:0] sel, logic has_fixed = 1'b0,
                            verdict_t fixed = '0);
        text_row_t r;
        for (int i = 0; i < s.len(); i++) begin
            r.b = s[i];
            r.last = (i == s.len() - 1);
            r.sel = sel;
            r.has_fixed = r.last && has_fixed;
            r.fixed = fixed;
            rows.push_back(r);
        end
    endtask

    // Random text mostly built from aliases, neighbours, mutations and noise
    task automatic send_random_text(int beats_max);
        string txt, p;
        logic [2:0] sel;
        int g, a, n;
        txt = "";
        n = $urandom_range(1, 6);
        for (int w = 0; w < n; w++) begin
            case ($urandom_range(0, 5)) inside
                [0:2]: begin
                    do begin
                        g = $urandom_range(0, N_GROUPS - 1);
                        a = $urandom_range(0, 6);
                    end while (phrase_rom[g][a].len() == 0);
                    p = phrase_rom[g][a];
                    if ($urandom_range(0, 3) == 0) p = p.toupper();
                    if ($urandom_range(0, 5) == 0) p[$urandom_range(0, p.len()-1)] =
                        8'($urandom_range(1, 255));
                end
                3: p = $sformatf("%c", 8'($urandom_range(128, 255)));
                4: p = "x";
                default: begin
                    p = "";
                    repeat ($urandom_range(1, 5)) p = {p, $sformatf("%c",
                        8'($urandom_range(1, 255)))};
                end
            endcase
            txt = {txt, p};
            case ($urandom_range(0, 4))
                0: txt = {txt, "\303"};
                1: txt = {txt, ".,"};
                2: ;
                default: txt = {txt, " "};
            endcase
        end
        if ($urandom_range(0, 3) == 0) txt = {" !", txt};
        if (txt.len() > beats_max) txt = txt.substr(0, beats_max - 1);
        sel = $urandom_range(0, 9) < 5 ? awm_pkg::SEL_ALL : 3'($urandom_range(0, 7));
        for (int i = 0; i < txt.len(); i++)
            send_beat(txt[i], i == txt.len() - 1, sel);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (verdicts_due.size() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    initial begin
        verdict_t none, v;
        string    big;
        none = '0;
        errors = 0;
        results_seen = 0;
        beats_sent = 0;
        burst = 0;
        long_hold = 1'b0;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= 8'h00;
        s_tlast  <= 1'b0;
        s_tuser  <= 3'd0;
        clear_text_state();
        text_sel = awm_pkg::SEL_ALL;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table: extremes of the bytes, each selector, boundary rules
        v = '{alias_idx: 4'd0, group_idx: 3'd0, found: 1'b1};
        add_text("grapefruit", awm_pkg::SEL_ALL, 1'b1, v);
        add_text("GrapeFruit!", 3'd0, 1'b1, v);
        add_text("grapefruit", 3'd7, 1'b1, none);            // unknown selector
        add_text("grapefruit", 3'd1, 1'b1, none);            // wrong group
        add_text("xgrapefruit", awm_pkg::SEL_ALL, 1'b1, none); // no left boundary
        add_text("grapefruit_", awm_pkg::SEL_ALL, 1'b1, none); // no right boundary
        add_text("\001\377", awm_pkg::SEL_ALL, 1'b1, none);  // byte extremes
        add_text("  recipiente,,fechado  ", 3'd4);           // separator runs
        add_text("\200fogo\377", 3'd5);                      // high bytes as boundaries
        add_text("pomelo-grapefruit", awm_pkg::SEL_ALL);
        add_text("ppomelo pomelo", 3'd0);                    // overlapping partial
        add_text("saneante bleach cloro", 3'd3);
        add_text("al\303\251rgico crian\303\247a", awm_pkg::SEL_ALL);
        add_text("energia micro-ondas", 3'd5);
        add_text("bebe", 3'd2, 1'b1, none);
        foreach (rows[i])
            send_beat(rows[i].b, rows[i].last, rows[i].sel, rows[i].has_fixed,
                      rows[i].fixed);

        // Over-long text: the alias falls beyond the kept characters
        big = "";
        repeat (TEXT_CAP - 4) big = {big, "a"};
        big = {big, " fogo chama"};
        for (int i = 0; i < big.len(); i++)
            send_beat(big[i], i == big.len() - 1, awm_pkg::SEL_ALL);

        // Sender pauses until every verdict has come back
        wait_drained();

        // Long receiver hold-off while beats keep being offered
        long_hold = 1'b1;
        repeat (2) @(posedge aclk);
        long_hold = 1'b0;
        for (int t = 0; t < 30; t++) send_beat("a", 1'b1, awm_pkg::SEL_ALL);

        while (beats_sent < 2000) send_random_text(40);

        wait_drained();
        repeat (10) @(posedge aclk);
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule

FILE: filelist.f
design/awm_pkg.sv
design/awm_char_cell.sv
design/awm_alias_cell.sv
design/alias_keyword_whole_word_matcher.sv
tb/tb_alias_keyword_whole_word_matcher.sv
